>>> design/cau_pkg.sv
// Shared types and codes for the complex arithmetic unit.
`default_nettype none

package cau_pkg;

  // Operation codes
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_DZ  = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  // One quotient bit per divider stage
  localparam int DIV_STEPS = 32;

  // Per-component working data
  typedef struct packed {
    logic               neg;   // quotient sign
    logic               ovf;   // quotient integer part too large
    logic [63:0]        rem;   // partial remainder
    logic [31:0]        work;  // dividend bits left, quotient bits shifted in
    logic signed [49:0] lin;   // add/sub/mul value before clamping
  } lane_t;

  typedef struct packed {
    logic [1:0]  op;
    logic        dz;           // divide with zero divisor
    logic [63:0] den;          // squared magnitude of the right operand
    lane_t       re;
    lane_t       im;
  } item_t;

endpackage

`default_nettype wire

>>> design/cau_front.sv
// Operand capture, products, sums, magnitudes and divider setup (five stages).
`default_nettype none

module cau_front
  import cau_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               up_valid,
  output logic                    up_ready,
  input  wire logic [1:0]         up_op,
  input  wire logic signed [31:0] up_a,
  input  wire logic signed [31:0] up_b,
  input  wire logic signed [31:0] up_c,
  input  wire logic signed [31:0] up_d,
  output logic                    dn_valid,
  input  wire logic               dn_ready,
  output item_t                   dn_item
);

  logic v0_r, v1_r, v2_r, v3_r, v4_r;
  logic rdy0, rdy1, rdy2, rdy3, rdy4;

  // Stage 0 registers
  logic [1:0]         op0_r;
  logic signed [31:0] a0_r, b0_r, c0_r, d0_r;

  // Stage 1 registers
  logic [1:0]         op1_r;
  logic               dz1_r;
  logic signed [63:0] ac1_r, bd1_r, ad1_r, bc1_r, cc1_r, dd1_r;
  logic signed [32:0] sa1_r, sb1_r;
  logic signed [63:0] ac_nxt, bd_nxt, ad_nxt, bc_nxt, cc_nxt, dd_nxt;
  logic signed [32:0] sa_nxt, sb_nxt;

  // Stage 2 registers
  logic [1:0]         op2_r;
  logic               dz2_r;
  logic [63:0]        den2_r;
  logic signed [64:0] p2_r, q2_r;
  logic signed [49:0] lr2_r, li2_r;
  logic signed [64:0] p_nxt, q_nxt;
  logic [63:0]        den_nxt;
  logic signed [49:0] lr_nxt, li_nxt;

  // Stage 3 registers
  logic [1:0]         op3_r;
  logic               dz3_r;
  logic [63:0]        den3_r;
  logic               nr3_r, ni3_r;
  logic [63:0]        mr3_r, mi3_r;
  logic signed [49:0] lr3_r, li3_r;
  logic signed [64:0] pn_nxt, qn_nxt;

  // Stage 4 register
  item_t              item4_r;
  item_t              item_nxt;

  // Ready chain: a stage loads when empty or when it moves on
  assign rdy4     = !v4_r || dn_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign rdy0     = !v0_r || rdy1;
  assign up_ready = rdy0;
  assign dn_valid = v4_r;
  assign dn_item  = item4_r;

  // Products and linear sums
  always_comb begin
    ac_nxt = a0_r * c0_r;
    bd_nxt = b0_r * d0_r;
    ad_nxt = a0_r * d0_r;
    bc_nxt = b0_r * c0_r;
    cc_nxt = c0_r * c0_r;
    dd_nxt = d0_r * d0_r;
    sa_nxt = (op0_r == OP_SUB) ? (a0_r - c0_r) : (a0_r + c0_r);
    sb_nxt = (op0_r == OP_SUB) ? (b0_r - d0_r) : (b0_r + d0_r);
  end

  // Cross sums, divisor and floor-scaled product
  always_comb begin
    p_nxt   = (op1_r == OP_DIV) ? (ac1_r + bd1_r) : (ac1_r - bd1_r);
    q_nxt   = (op1_r == OP_DIV) ? (bc1_r - ad1_r) : (ad1_r + bc1_r);
    den_nxt = $unsigned(cc1_r) + $unsigned(dd1_r);
    if (op1_r == OP_MUL) begin
      lr_nxt = {p_nxt[64], p_nxt[64:16]};
      li_nxt = {q_nxt[64], q_nxt[64:16]};
    end else begin
      lr_nxt = {{17{sa1_r[32]}}, sa1_r};
      li_nxt = {{17{sb1_r[32]}}, sb1_r};
    end
  end

  // Magnitudes
  assign pn_nxt = -p2_r;
  assign qn_nxt = -q2_r;

  // Divider setup: overflow check and initial remainder
  always_comb begin
    item_nxt.op      = op3_r;
    item_nxt.dz      = dz3_r;
    item_nxt.den     = den3_r;
    item_nxt.re.neg  = nr3_r;
    item_nxt.re.ovf  = {16'd0, mr3_r} >= {den3_r, 16'd0};
    item_nxt.re.rem  = {16'd0, mr3_r[63:16]};
    item_nxt.re.work = {mr3_r[15:0], 16'd0};
    item_nxt.re.lin  = lr3_r;
    item_nxt.im.neg  = ni3_r;
    item_nxt.im.ovf  = {16'd0, mi3_r} >= {den3_r, 16'd0};
    item_nxt.im.rem  = {16'd0, mi3_r[63:16]};
    item_nxt.im.work = {mi3_r[15:0], 16'd0};
    item_nxt.im.lin  = li3_r;
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy0) v0_r <= up_valid;
      if (rdy1) v1_r <= v0_r;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // Payload, loaded with the valid bit
  always_ff @(posedge clk) begin
    if (rdy0 && up_valid) begin
      op0_r <= up_op;
      a0_r  <= up_a;
      b0_r  <= up_b;
      c0_r  <= up_c;
      d0_r  <= up_d;
    end
    if (rdy1 && v0_r) begin
      op1_r <= op0_r;
      dz1_r <= (op0_r == OP_DIV) && (c0_r == '0) && (d0_r == '0);
      ac1_r <= ac_nxt;
      bd1_r <= bd_nxt;
      ad1_r <= ad_nxt;
      bc1_r <= bc_nxt;
      cc1_r <= cc_nxt;
      dd1_r <= dd_nxt;
      sa1_r <= sa_nxt;
      sb1_r <= sb_nxt;
    end
    if (rdy2 && v1_r) begin
      op2_r  <= op1_r;
      dz2_r  <= dz1_r;
      den2_r <= den_nxt;
      p2_r   <= p_nxt;
      q2_r   <= q_nxt;
      lr2_r  <= lr_nxt;
      li2_r  <= li_nxt;
    end
    if (rdy3 && v2_r) begin
      op3_r  <= op2_r;
      dz3_r  <= dz2_r;
      den3_r <= den2_r;
      nr3_r  <= p2_r[64];
      ni3_r  <= q2_r[64];
      mr3_r  <= p2_r[64] ? pn_nxt[63:0] : p2_r[63:0];
      mi3_r  <= q2_r[64] ? qn_nxt[63:0] : q2_r[63:0];
      lr3_r  <= lr2_r;
      li3_r  <= li2_r;
    end
    if (rdy4 && v3_r) begin
      item4_r <= item_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/cau_div_stage.sv
// One restoring-division stage: one quotient bit for each component.
`default_nettype none

module cau_div_stage
  import cau_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  up_valid,
  output logic       up_ready,
  input  wire item_t up_item,
  output logic       dn_valid,
  input  wire logic  dn_ready,
  output item_t      dn_item
);

  logic  valid_r;
  item_t item_r;
  item_t item_nxt;
  logic [64:0] tr, ti;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_item  = item_r;

  // Shift in the next dividend bit, subtract the divisor when it fits
  always_comb begin
    item_nxt = up_item;
    tr = {up_item.re.rem, up_item.re.work[31]};
    ti = {up_item.im.rem, up_item.im.work[31]};
    if (tr >= {1'b0, up_item.den}) begin
      item_nxt.re.rem  = 64'(tr - {1'b0, up_item.den});
      item_nxt.re.work = {up_item.re.work[30:0], 1'b1};
    end else begin
      item_nxt.re.rem  = tr[63:0];
      item_nxt.re.work = {up_item.re.work[30:0], 1'b0};
    end
    if (ti >= {1'b0, up_item.den}) begin
      item_nxt.im.rem  = 64'(ti - {1'b0, up_item.den});
      item_nxt.im.work = {up_item.im.work[30:0], 1'b1};
    end else begin
      item_nxt.im.rem  = ti[63:0];
      item_nxt.im.work = {up_item.im.work[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      item_r <= item_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/cau_back.sv
// Saturation, status and the output register.
`default_nettype none

module cau_back
  import cau_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  up_valid,
  output logic       up_ready,
  input  wire item_t up_item,
  output logic       dn_valid,
  input  wire logic  dn_ready,
  output logic [31:0] dn_real,
  output logic [31:0] dn_imag,
  output logic [1:0]  dn_status
);

  logic        valid_r;
  logic [31:0] real_r, imag_r;
  logic [1:0]  status_r;
  logic [31:0] real_nxt, imag_nxt;
  logic [1:0]  status_nxt;
  logic        sat_re, sat_im;

  // Clamp a linear value to Q16.16
  function automatic logic [32:0] clamp_lin(input logic signed [49:0] v);
    logic hi_ok;
    hi_ok = (v[49:31] == '0) || (v[49:31] == '1);
    if (hi_ok)      clamp_lin = {1'b0, v[31:0]};
    else if (v[49]) clamp_lin = {1'b1, 32'h8000_0000};
    else            clamp_lin = {1'b1, 32'h7FFF_FFFF};
  endfunction

  // Apply sign to a quotient and clamp it
  function automatic logic [32:0] clamp_quo(input lane_t l);
    logic [31:0] neg_q;
    neg_q = 32'(~l.work + 32'd1);
    if (l.ovf)
      clamp_quo = l.neg ? {1'b1, 32'h8000_0000} : {1'b1, 32'h7FFF_FFFF};
    else if (!l.neg)
      clamp_quo = l.work[31] ? {1'b1, 32'h7FFF_FFFF} : {1'b0, l.work};
    else if (l.work > 32'h8000_0000)
      clamp_quo = {1'b1, 32'h8000_0000};
    else
      clamp_quo = {1'b0, neg_q};
  endfunction

  always_comb begin
    logic [32:0] rr, ri;
    if (up_item.op == OP_DIV) begin
      rr = clamp_quo(up_item.re);
      ri = clamp_quo(up_item.im);
    end else begin
      rr = clamp_lin(up_item.re.lin);
      ri = clamp_lin(up_item.im.lin);
    end
    sat_re = rr[32];
    sat_im = ri[32];
    if (up_item.dz) begin
      real_nxt   = '0;
      imag_nxt   = '0;
      status_nxt = ST_DZ;
    end else begin
      real_nxt   = rr[31:0];
      imag_nxt   = ri[31:0];
      status_nxt = (sat_re || sat_im) ? ST_SAT : ST_OK;
    end
  end

  assign up_ready  = !valid_r || dn_ready;
  assign dn_valid  = valid_r;
  assign dn_real   = real_r;
  assign dn_imag   = imag_r;
  assign dn_status = status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  // Hold the result until the request is taken
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      real_r   <= real_nxt;
      imag_r   <= imag_nxt;
      status_r <= status_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/complex_arithmetic_unit_core.sv
// Complex add, subtract, multiply and divide in Q16.16, registered through five front
// stages, 32 divider stages of one quotient bit each and one output stage; one request
// per cycle sustained for every operation while out_tready stays high. Reset clears
// the valid bits of all stages; no other state.
`default_nettype none

module complex_arithmetic_unit_core
  import cau_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [127:0] in_tdata,  // lhs_re, lhs_im, rhs_re, rhs_im
  input  wire logic [1:0]   in_tuser,  // action
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [63:0]       out_tdata, // result_real, result_imag
  output logic [1:0]        out_tuser  // status
);

  item_t              st_item  [0:DIV_STEPS];
  logic [DIV_STEPS:0] st_valid;
  logic [DIV_STEPS:0] st_ready;
  logic [31:0]        res_real, res_imag;

  cau_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .up_op    (in_tuser),
    .up_a     (in_tdata[31:0]),
    .up_b     (in_tdata[63:32]),
    .up_c     (in_tdata[95:64]),
    .up_d     (in_tdata[127:96]),
    .dn_valid (st_valid[0]),
    .dn_ready (st_ready[0]),
    .dn_item  (st_item[0])
  );

  // Divider chain
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    cau_div_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (st_valid[i]),
      .up_ready (st_ready[i]),
      .up_item  (st_item[i]),
      .dn_valid (st_valid[i+1]),
      .dn_ready (st_ready[i+1]),
      .dn_item  (st_item[i+1])
    );
  end

  cau_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (st_valid[DIV_STEPS]),
    .up_ready  (st_ready[DIV_STEPS]),
    .up_item   (st_item[DIV_STEPS]),
    .dn_valid  (out_tvalid),
    .dn_ready  (out_tready),
    .dn_real   (res_real),
    .dn_imag   (res_imag),
    .dn_status (out_tuser)
  );

  assign out_tdata = {res_imag, res_real};

endmodule

`default_nettype wire

>>> test/complex_arithmetic_unit_core_check.sv
// Checker for the complex arithmetic unit: predicts each result and compares it.
`timescale 1ns / 100ps

module complex_arithmetic_unit_core_check
  import cau_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  input  wire logic         in_tready,
  input  wire logic [127:0] in_tdata,
  input  wire logic [1:0]   in_tuser,
  input  wire logic         out_tvalid,
  input  wire logic         out_tready,
  input  wire logic [63:0]  out_tdata,
  input  wire logic [1:0]   out_tuser,
  output int                fail_count,
  output int                pending
);

  typedef struct {
    logic [31:0] re;
    logic [31:0] im;
    logic [1:0]  st;
  } cplx_result_t;

  cplx_result_t result_queue[$];

  // Clamp a signed wide value into Q16.16
  function automatic logic [31:0] clamp_q16(input logic signed [80:0] v, inout bit sat);
    if (v > 81'sd2147483647) begin
      sat = 1;
      return 32'h7fffffff;
    end
    if (v < -81'sd2147483648) begin
      sat = 1;
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  // Signed numerator over positive denominator, truncated toward zero, in Q16.16
  function automatic logic [31:0] quot_q16(input logic signed [80:0] num,
                                           input logic [80:0] den, inout bit sat);
    logic [80:0] mag;
    logic [80:0] q;
    logic signed [80:0] sq;
    mag = num[80] ? -num : num;
    q = (mag << 16) / den;
    sq = num[80] ? -$signed(q) : $signed(q);
    return clamp_q16(sq, sat);
  endfunction

  function automatic cplx_result_t compute_result(input logic [1:0] op,
                                                  input logic [127:0] d);
    logic signed [80:0] a, b, c, e, num, den;
    cplx_result_t r;
    bit sat;
    a = $signed(d[31:0]);
    b = $signed(d[63:32]);
    c = $signed(d[95:64]);
    e = $signed(d[127:96]);
    sat = 0;
    r.st = ST_OK;
    r.re = '0;
    r.im = '0;
    case (op)
      OP_ADD: begin
        r.re = clamp_q16(a + c, sat);
        r.im = clamp_q16(b + e, sat);
      end
      OP_SUB: begin
        r.re = clamp_q16(a - c, sat);
        r.im = clamp_q16(b - e, sat);
      end
      OP_MUL: begin
        // arithmetic shift floors toward minus infinity
        num = a * c - b * e;
        r.re = clamp_q16(num >>> 16, sat);
        num = a * e + b * c;
        r.im = clamp_q16(num >>> 16, sat);
      end
      default: begin
        if (c == 0 && e == 0) begin
          r.st = ST_DZ;
        end else begin
          den = c * c + e * e;
          r.re = quot_q16(a * c + b * e, den, sat);
          r.im = quot_q16(b * c - a * e, den, sat);
        end
      end
    endcase
    if (r.st == ST_OK && sat) r.st = ST_SAT;
    return r;
  endfunction

  assign pending = result_queue.size();

  always @(posedge clk) begin
    cplx_result_t exp_r;
    int errs;
    errs = 0;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_tvalid && in_tready) result_queue.push_back(compute_result(in_tuser, in_tdata));
      if (out_tvalid && out_tready) begin
        if (result_queue.size() == 0) begin
          $error("unexpected result %h status %0d", out_tdata, out_tuser);
          errs = errs + 1;
        end else begin
          exp_r = result_queue.pop_front();
          if (out_tdata[31:0] !== exp_r.re) begin
            $error("result_real expected %h actual %h", exp_r.re, out_tdata[31:0]);
            errs = errs + 1;
          end
          if (out_tdata[63:32] !== exp_r.im) begin
            $error("result_imag expected %h actual %h", exp_r.im, out_tdata[63:32]);
            errs = errs + 1;
          end
          if (out_tuser !== exp_r.st) begin
            $error("status expected %0d actual %0d", exp_r.st, out_tuser);
            errs = errs + 1;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end

endmodule

>>> test/complex_arithmetic_unit_core_test.sv
// Top of the complex arithmetic unit testbench: stimulus, backpressure and verdict.
`timescale 1ns / 100ps

module complex_arithmetic_unit_core_test;
  import cau_pkg::*;

  localparam int LATENCY   = 38;
  localparam int HANG_MAX  = 5000;
  localparam int RAND_ITEMS = 1000;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;   // lhs_re, lhs_im, rhs_re, rhs_im
  logic [1:0]   in_tuser;   // action
  logic         out_tvalid;
  logic         out_tready;
  logic [63:0]  out_tdata;  // result_real, result_imag
  logic [1:0]   out_tuser;  // status
  int           fail_count;
  int           pending;
  int           send_idle_pct;
  int           recv_idle_pct;
  int           hold_cycles;
  int           idle_count;

  complex_arithmetic_unit_core i_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser
  );

  complex_arithmetic_unit_core_check i_check (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .fail_count, .pending
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Randomly stall the receiver; hold it off entirely while hold_cycles runs down
  initial out_tready = 1'b0;
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: count cycles with no request accepted on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_count <= 0;
    end else begin
      idle_count <= idle_count + 1;
      if (idle_count >= HANG_MAX) begin
        $display("complex_arithmetic_unit_core_test: FAIL");
        $finish;
      end
    end
  end

  function automatic logic [31:0] pick_part();
    case ($urandom_range(7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return $urandom_range(1) ? 32'h00010000 : 32'hffff0000;
      4, 5: return {{16{1'b0}}, 16'($urandom)} - 32'h8000 + ($urandom_range(15) << 16)
                   - 32'h00080000;
      default: return $urandom;
    endcase
  endfunction

  // Offer one request and hold it until accepted
  task automatic send_op(input logic [1:0] op, input logic [31:0] lr, input logic [31:0] li,
                         input logic [31:0] rr, input logic [31:0] ri);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {ri, rr, li, lr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_random(input int count);
    for (int n = 0; n < count; n++) begin
      send_op(2'($urandom_range(3)), pick_part(), pick_part(), pick_part(), pick_part());
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = OP_ADD;
    hold_cycles = 0;
    idle_count  = 0;
    send_idle_pct = 20;
    recv_idle_pct = 87;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: each operation, extremes, saturation and zero divisor
    send_op(OP_ADD, 32'h7fffffff, 32'h80000000, 32'h00000001, 32'hffffffff);
    send_op(OP_ADD, 32'h00010000, 32'h00020000, 32'h00030000, 32'hfffc0000);
    send_op(OP_SUB, 32'h80000000, 32'h7fffffff, 32'h00000001, 32'hffffffff);
    send_op(OP_SUB, 32'h00050000, 32'h0, 32'h00020000, 32'h0);
    send_op(OP_MUL, 32'h00020000, 32'h00030000, 32'h00040000, 32'hfffb0000);
    send_op(OP_MUL, 32'hffffffff, 32'h0, 32'h00000001, 32'h0);
    send_op(OP_MUL, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
    send_op(OP_MUL, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
    send_op(OP_DIV, 32'h00010000, 32'h00010000, 32'h0, 32'h0);
    send_op(OP_DIV, 32'h80000000, 32'h7fffffff, 32'h0, 32'h0);
    send_op(OP_DIV, 32'h00010000, 32'h0, 32'h00030000, 32'h0);
    send_op(OP_DIV, 32'hfffe0000, 32'h00050000, 32'h00010000, 32'h00020000);
    send_op(OP_DIV, 32'h7fffffff, 32'h80000000, 32'h00000001, 32'h0);
    send_op(OP_DIV, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
    send_op(OP_DIV, 32'h00000001, 32'hffffffff, 32'h7fffffff, 32'h7fffffff);
    send_op(OP_DIV, 32'h0, 32'h0, 32'h0, 32'h00000001);

    send_random(RAND_ITEMS / 3);
    send_idle_pct = 87;
    recv_idle_pct = 20;
    send_random(RAND_ITEMS / 3);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // Long receiver hold-off while the sender keeps offering
    hold_cycles <= 200;
    send_random(RAND_ITEMS / 3);
    in_tvalid <= 1'b0;

    // Drain, then let the pipeline settle
    while (pending > 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0) begin
      $display("complex_arithmetic_unit_core_test: PASS");
    end else begin
      $display("complex_arithmetic_unit_core_test: FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
design/cau_pkg.sv
design/cau_front.sv
design/cau_div_stage.sv
design/cau_back.sv
design/complex_arithmetic_unit_core.sv
test/complex_arithmetic_unit_core_check.sv
test/complex_arithmetic_unit_core_test.sv
